// ----- rtl/mm_pkg.sv -----
// shared types and constants of the matrix multiply block
package mm_pkg;

  // default largest matrix dimension
  localparam int MAX_DIM_DEF = 8;

  // field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 3;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int SUM_W  = 35;
  localparam int DIM_W  = 4;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  // dimension register reset value
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } mm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic res_loaded;
  } mm_status_t;

endpackage

// ----- rtl/mm_in_if.sv -----
// input channel interface: element loads and compute requests
interface mm_in_if;
  logic                             valid;
  logic                             ready;
  logic [mm_pkg::OP_W-1:0]          op;
  logic [mm_pkg::IDX_W-1:0]         row;
  logic [mm_pkg::IDX_W-1:0]         col;
  logic signed [mm_pkg::VAL_W-1:0]  value;

  modport source (output valid, op, row, col, value, input ready);
  modport sink   (input valid, op, row, col, value, output ready);
endinterface

// ----- rtl/mm_out_if.sv -----
// result channel interface: one element of the product per transaction
interface mm_out_if;
  logic                             valid;
  logic                             ready;
  logic [mm_pkg::IDX_W-1:0]         out_row;
  logic [mm_pkg::IDX_W-1:0]         out_col;
  logic signed [mm_pkg::SUM_W-1:0]  sum;
  logic                             last;

  modport source (output valid, out_row, out_col, sum, last, input ready);
  modport sink   (input valid, out_row, out_col, sum, last, output ready);
endinterface

// ----- rtl/matrix_multiply.sv -----
// top level of the matrix multiply block
//
// Computes C = A * B on signed Q8.8 elements, each result an exact signed Q19.16
// sum (35 bits). Load transactions (op 0 for A, op 1 for B) write one element and
// are taken one per cycle; a load whose row or column is at or beyond MAX_DIM and
// op 3 are dropped. A compute transaction (op 2) emits rows_a * cols_b results in
// row-major order, the final one flagged with last. Each result element sums one
// product per cycle through the single shared 16x16 multiplier fed by one read
// port of each element store, then passes the read, product and accumulate
// stages; output backpressure can stall it. No new transaction is taken while a
// compute runs, but loads and the next compute are accepted while its final
// result still waits in the output register. Elements never written read as
// undefined. Dimension registers read 0 as 1 and values above MAX_DIM as MAX_DIM;
// the user must write them only while the block is idle; nothing enforces it.
module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]      cfg_data,
  mm_in_if.sink                         in_ch,
  mm_out_if.source                      out_ch
);

  mm_pkg::mm_cmd_t    cmd;
  mm_pkg::mm_status_t status;

  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .cmd       (cmd),
    .status    (status)
  );

  mm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_value  (in_ch.value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_sum   (out_ch.sum),
    .out_last  (out_ch.last)
  );

endmodule

// ----- rtl/mm_ram.sv -----
// generic single write port ram with registered read
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mm_ctrl.sv -----
// controller: dimension registers, transaction acceptance and loop sequencing
module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]        cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mm_pkg::OP_W-1:0]         in_op,
  input  logic [mm_pkg::IDX_W-1:0]        in_row,
  input  logic [mm_pkg::IDX_W-1:0]        in_col,
  output mm_pkg::mm_cmd_t                 cmd,
  input  mm_pkg::mm_status_t              status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  state_t                        state_r;
  logic [mm_pkg::DIM_W-1:0]      rows_a_r;
  logic [mm_pkg::DIM_W-1:0]      inner_dim_r;
  logic [mm_pkg::DIM_W-1:0]      cols_b_r;
  logic [mm_pkg::IDX_W-1:0]      i_r;
  logic [mm_pkg::IDX_W-1:0]      j_r;
  logic [mm_pkg::IDX_W-1:0]      k_r;
  logic [mm_pkg::IDX_W-1:0]      lim_i;
  logic [mm_pkg::IDX_W-1:0]      lim_k;
  logic [mm_pkg::IDX_W-1:0]      lim_c;
  logic                          in_fire;
  logic                          in_range;
  logic                          last_elem;

  // highest index in use: zero acts as one, large values as MAX_DIM
  function automatic logic [mm_pkg::IDX_W-1:0] dim_lim(input logic [mm_pkg::DIM_W-1:0] v);
    logic [mm_pkg::IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (32'(v) > MAX_DIM) begin
      res = mm_pkg::IDX_W'(MAX_DIM - 1);
    end else begin
      res = mm_pkg::IDX_W'(v - 4'd1);
    end
    return res;
  endfunction

  assign lim_i = dim_lim(rows_a_r);
  assign lim_k = dim_lim(inner_dim_r);
  assign lim_c = dim_lim(cols_b_r);

  // input handshake
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_range  = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign last_elem = (i_r == lim_i) && (j_r == lim_c);

  // commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.wr_a      = in_fire && in_range && (in_op == mm_pkg::OP_LOAD_A);
    cmd.wr_b      = in_fire && in_range && (in_op == mm_pkg::OP_LOAD_B);
    cmd.issue     = (state_r == ST_ISSUE);
    cmd.first     = (k_r == '0);
    cmd.last_k    = (k_r == lim_k);
    cmd.last_elem = last_elem;
    cmd.i         = i_r;
    cmd.j         = j_r;
    cmd.k         = k_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mm_pkg::DIM_RESET;
      inner_dim_r <= mm_pkg::DIM_RESET;
      cols_b_r    <= mm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mm_pkg::CFG_ROWS_A:    rows_a_r    <= cfg_data;
        mm_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_data;
        mm_pkg::CFG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // loop sequencer over result elements and summation index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_op == mm_pkg::OP_COMPUTE)) begin
            i_r     <= '0;
            j_r     <= '0;
            k_r     <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_r == lim_k) begin
            k_r     <= '0;
            state_r <= ST_WAIT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_WAIT: begin
          if (status.res_loaded) begin
            if (last_elem) begin
              state_r <= ST_IDLE;
            end else begin
              if (j_r == lim_c) begin
                j_r <= '0;
                i_r <= i_r + 1'b1;
              end else begin
                j_r <= j_r + 1'b1;
              end
              state_r <= ST_ISSUE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mm_dp.sv -----
// datapath: element stores, multiply and accumulate pipeline, result register
module mm_dp #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mm_pkg::mm_cmd_t                  cmd,
  output mm_pkg::mm_status_t               status,
  input  logic [mm_pkg::IDX_W-1:0]         in_row,
  input  logic [mm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mm_pkg::VAL_W-1:0]  in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mm_pkg::IDX_W-1:0]         out_row,
  output logic [mm_pkg::IDX_W-1:0]         out_col,
  output logic signed [mm_pkg::SUM_W-1:0]  out_sum,
  output logic                             out_last
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [ADDR_W-1:0]                  waddr;
  logic [ADDR_W-1:0]                  a_raddr;
  logic [ADDR_W-1:0]                  b_raddr;
  logic [mm_pkg::VAL_W-1:0]           a_rdata;
  logic [mm_pkg::VAL_W-1:0]           b_rdata;
  logic                               rd_vld_r;
  logic                               rd_first_r;
  logic                               rd_last_r;
  logic signed [mm_pkg::PROD_W-1:0]   prod_r;
  logic                               prod_vld_r;
  logic                               prod_first_r;
  logic                               prod_last_r;
  logic signed [mm_pkg::SUM_W-1:0]    acc_r;
  logic signed [mm_pkg::SUM_W-1:0]    acc_nxt;
  logic signed [mm_pkg::SUM_W-1:0]    prod_ext;
  logic                               acc_done_r;
  logic                               load;
  logic                               out_valid_r;
  logic [mm_pkg::IDX_W-1:0]           out_row_r;
  logic [mm_pkg::IDX_W-1:0]           out_col_r;
  logic signed [mm_pkg::SUM_W-1:0]    out_sum_r;
  logic                               out_last_r;

  // store addresses, row-major with a stride of MAX_DIM
  assign waddr   = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign a_raddr = ADDR_W'(32'(cmd.i) * MAX_DIM + 32'(cmd.k));
  assign b_raddr = ADDR_W'(32'(cmd.k) * MAX_DIM + 32'(cmd.j));

  mm_ram #(.WIDTH(mm_pkg::VAL_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (waddr),
    .wdata (in_value),
    .re    (cmd.issue),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_ram #(.WIDTH(mm_pkg::VAL_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (waddr),
    .wdata (in_value),
    .re    (cmd.issue),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // pipeline control alongside the read and product stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  // flags follow the data, product of the two store elements
  always_ff @(posedge clk) begin
    rd_first_r   <= cmd.first;
    rd_last_r    <= cmd.last_k;
    prod_first_r <= rd_first_r;
    prod_last_r  <= rd_last_r;
    prod_r       <= $signed(a_rdata) * $signed(b_rdata);
  end

  // accumulate, restarting on the first product of an element
  assign prod_ext = {{(mm_pkg::SUM_W - mm_pkg::PROD_W){prod_r[mm_pkg::PROD_W-1]}}, prod_r};
  assign acc_nxt  = prod_first_r ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // finished sum moves to the result register once that is free
  assign load              = acc_done_r && (!out_valid_r || out_ready);
  assign status.res_loaded = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (prod_vld_r && prod_last_r) begin
        acc_done_r <= 1'b1;
      end else if (load) begin
        acc_done_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r  <= cmd.i;
      out_col_r  <= cmd.j;
      out_sum_r  <= acc_r;
      out_last_r <= cmd.last_elem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_sum   = out_sum_r;
  assign out_last  = out_last_r;

endmodule

// ----- sim/matrix_multiply_test.sv -----
// testbench for the matrix multiply block: directed and random loads and computes checked against a predictor
`timescale 1ns / 1ps

module matrix_multiply_test;

  localparam int DIM = mm_pkg::MAX_DIM_DEF;
  localparam logic [mm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  // longest quiet stretch before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // idle cycles waited after the last expected element has come back
  localparam int SETTLE_CYCLES = 16;
  localparam int N_PHASES = 8;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [mm_pkg::OP_W-1:0]         op;
    logic [mm_pkg::IDX_W-1:0]        row;
    logic [mm_pkg::IDX_W-1:0]        col;
    logic signed [mm_pkg::VAL_W-1:0] value;
  } in_item_t;

  typedef struct {
    logic [mm_pkg::IDX_W-1:0]        row;
    logic [mm_pkg::IDX_W-1:0]        col;
    logic signed [mm_pkg::SUM_W-1:0] sum;
    logic                            last;
  } c_elem_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mm_pkg::DIM_W-1:0] cfg_data;

  mm_in_if in_bus ();
  mm_out_if out_bus ();

  matrix_multiply dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // transactions waiting to be sent and product elements still due
  in_item_t items_to_send[$];
  c_elem_t  c_elems_due[$];

  // predictor copy of the element stores and dimension registers
  logic signed [mm_pkg::VAL_W-1:0] shadow_a [DIM*DIM];
  logic signed [mm_pkg::VAL_W-1:0] shadow_b [DIM*DIM];
  logic [mm_pkg::DIM_W-1:0] dim_rows = mm_pkg::DIM_RESET;
  logic [mm_pkg::DIM_W-1:0] dim_inner = mm_pkg::DIM_RESET;
  logic [mm_pkg::DIM_W-1:0] dim_cols = mm_pkg::DIM_RESET;

  // elements written so far, tracked on the stimulus side
  bit loaded_a [DIM*DIM];
  bit loaded_b [DIM*DIM];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int items_queued = 0;
  int items_accepted = 0;
  int items_made = 0;
  int loads_seen = 0;
  int computes_seen = 0;
  int elems_checked = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  // phase table: raw dimension values, idling and transaction count
  int ph_rows [N_PHASES] = '{8, 1, 0, 15, 3, 8, 4, 5};
  int ph_inner [N_PHASES] = '{8, 1, 15, 0, 5, 8, 2, 7};
  int ph_cols [N_PHASES] = '{8, 1, 3, 9, 2, 1, 8, 6};
  int ph_count [N_PHASES] = '{130, 35, 40, 40, 40, 35, 35, 35};
  idle_mode_t ph_mode [N_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                      IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};

  function automatic int dim_used(logic [mm_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 40) $display("%0t ns: %s", $time, msg);
  endtask

  // predictor: apply one accepted transaction, queue the product elements it causes
  task automatic run_product_item(in_item_t it);
    int nr, nk, nc;
    longint acc;
    c_elem_t e;
    case (it.op)
      mm_pkg::OP_LOAD_A: begin
        loads_seen++;
        if (it.row < DIM && it.col < DIM) shadow_a[it.row*DIM + it.col] = it.value;
      end
      mm_pkg::OP_LOAD_B: begin
        loads_seen++;
        if (it.row < DIM && it.col < DIM) shadow_b[it.row*DIM + it.col] = it.value;
      end
      mm_pkg::OP_COMPUTE: begin
        computes_seen++;
        nr = dim_used(dim_rows);
        nk = dim_used(dim_inner);
        nc = dim_used(dim_cols);
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++)
              acc += longint'(shadow_a[i*DIM + k]) * longint'(shadow_b[k*DIM + j]);
            e.row = mm_pkg::IDX_W'(i);
            e.col = mm_pkg::IDX_W'(j);
            e.sum = acc[mm_pkg::SUM_W-1:0];
            e.last = (i == nr - 1) && (j == nc - 1);
            c_elems_due.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  // dimension register writes seen by the predictor
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        mm_pkg::CFG_ROWS_A:    dim_rows <= cfg_data;
        mm_pkg::CFG_INNER_DIM: dim_inner <= cfg_data;
        mm_pkg::CFG_COLS_B:    dim_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // driver: hold each transaction until accepted, then take the next from the queue
  always @(posedge clk) begin : drive_inputs
    in_item_t nxt;
    in_item_t cur;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) begin
        cur.op = in_bus.op;
        cur.row = in_bus.row;
        cur.col = in_bus.col;
        cur.value = in_bus.value;
        run_product_item(cur);
        items_accepted++;
      end
      if (items_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = items_to_send.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.op <= nxt.op;
        in_bus.row <= nxt.row;
        in_bus.col <= nxt.col;
        in_bus.value <= nxt.value;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) out_bus.ready <= 1'b0;
    else out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // monitor: compare each result transaction with the oldest element due
  always @(posedge clk) begin : check_results
    c_elem_t due;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      elems_checked++;
      if (c_elems_due.size() == 0) begin
        flag_error($sformatf("unexpected result row=%0d col=%0d sum=%0d last=%0b",
                             out_bus.out_row, out_bus.out_col, out_bus.sum, out_bus.last));
      end else begin
        due = c_elems_due.pop_front();
        if (out_bus.out_row !== due.row || out_bus.out_col !== due.col ||
            out_bus.sum !== due.sum || out_bus.last !== due.last)
          flag_error($sformatf({"mismatch exp row=%0d col=%0d sum=%0d last=%0b, ",
                                "got row=%0d col=%0d sum=%0d last=%0b"},
            due.row, due.col, due.sum, due.last,
            out_bus.out_row, out_bus.out_col, out_bus.sum, out_bus.last));
      end
    end
  end

  // watchdog on cycles with no transaction and no register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles, %0d elements still due",
                 $time, QUIET_LIMIT, c_elems_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_item(logic [mm_pkg::OP_W-1:0] op, int row, int col,
                            logic signed [mm_pkg::VAL_W-1:0] value);
    in_item_t it;
    it.op = op;
    it.row = mm_pkg::IDX_W'(row);
    it.col = mm_pkg::IDX_W'(col);
    it.value = value;
    items_to_send.push_back(it);
    items_queued++;
    if (op == mm_pkg::OP_LOAD_A) loaded_a[row*DIM + col] = 1'b1;
    if (op == mm_pkg::OP_LOAD_B) loaded_b[row*DIM + col] = 1'b1;
    if (op != OP_UNUSED) items_made++;
  endtask

  function automatic logic signed [mm_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return mm_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // compute request with random content in the ignored fields
  task automatic queue_compute();
    queue_item(mm_pkg::OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
               mm_pkg::VAL_W'($urandom));
  endtask

  // noise: unused op code or a load anywhere in the stores
  task automatic queue_noise();
    if ($urandom_range(0, 1) == 0)
      queue_item(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                 mm_pkg::VAL_W'($urandom));
    else
      queue_item($urandom_range(0, 1) ? mm_pkg::OP_LOAD_B : mm_pkg::OP_LOAD_A,
                 $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
  endtask

  // load sequence over the region in use, then usually a compute
  task automatic queue_product_seq(int nr, int nk, int nc);
    int ri, cj, n_extra;
    logic signed [mm_pkg::VAL_W-1:0] va, vb;
    if ($urandom_range(0, 3) == 0) begin
      // one row of A and one column of B at full scale
      ri = $urandom_range(0, nr - 1);
      cj = $urandom_range(0, nc - 1);
      va = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      vb = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      for (int k = 0; k < nk; k++) begin
        queue_item(mm_pkg::OP_LOAD_A, ri, k, va);
        queue_item(mm_pkg::OP_LOAD_B, k, cj, vb);
      end
    end else begin
      n_extra = $urandom_range(0, 10);
      for (int n = 0; n < n_extra; n++) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        if ($urandom_range(0, 1) == 0)
          queue_item(mm_pkg::OP_LOAD_A, $urandom_range(0, nr - 1),
                     $urandom_range(0, nk - 1), pick_value());
        else
          queue_item(mm_pkg::OP_LOAD_B, $urandom_range(0, nk - 1),
                     $urandom_range(0, nc - 1), pick_value());
      end
    end
    // every element the compute will read must have been written
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!loaded_a[i*DIM + k]) queue_item(mm_pkg::OP_LOAD_A, i, k, pick_value());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!loaded_b[k*DIM + j]) queue_item(mm_pkg::OP_LOAD_B, k, j, pick_value());
    // broken sequence now and then: loads with no compute
    if ($urandom_range(0, 7) != 0) begin
      queue_compute();
      if ($urandom_range(0, 5) == 0) queue_compute();
    end
  endtask

  task automatic write_dims(int r, int k, int c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mm_pkg::CFG_ROWS_A;
    cfg_data <= mm_pkg::DIM_W'(r);
    @(posedge clk);
    cfg_index <= mm_pkg::CFG_INNER_DIM;
    cfg_data <= mm_pkg::DIM_W'(k);
    @(posedge clk);
    cfg_index <= mm_pkg::CFG_COLS_B;
    cfg_data <= mm_pkg::DIM_W'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin src_idle_pct = 77; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 77; end
      IDLE_BOTH:     begin src_idle_pct = 30; sink_stall_pct = 30; end
      default:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endtask

  // wait until every queued transaction is taken and every element has come back
  task automatic drain_block(int tail);
    while (items_accepted != items_queued || c_elems_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // stimulus sequence: reset, directed checks, then random phases
  initial begin
    foreach (shadow_a[i]) begin
      shadow_a[i] = '0;
      shadow_b[i] = '0;
    end
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mm_pkg::CFG_ROWS_A;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.op = mm_pkg::OP_LOAD_A;
    in_bus.row = '0;
    in_bus.col = '0;
    in_bus.value = '0;
    out_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full-scale products, out-of-region loads, unused op, computes with only an unused op between
    write_dims(2, 2, 2);
    queue_item(mm_pkg::OP_LOAD_A, 0, 0, 16'sh8000);
    queue_item(mm_pkg::OP_LOAD_A, 0, 1, 16'sh8000);
    queue_item(mm_pkg::OP_LOAD_B, 0, 0, 16'sh8000);
    queue_item(mm_pkg::OP_LOAD_B, 1, 0, 16'sh8000);
    queue_item(mm_pkg::OP_LOAD_A, 1, 0, 16'sh7fff);
    queue_item(mm_pkg::OP_LOAD_A, 1, 1, 16'sh7fff);
    queue_item(mm_pkg::OP_LOAD_B, 0, 1, 16'sh7fff);
    queue_item(mm_pkg::OP_LOAD_B, 1, 1, 16'sh8000);
    queue_item(OP_UNUSED, 7, 7, -16'sd1);
    queue_item(mm_pkg::OP_LOAD_A, 7, 7, 16'sh7fff);
    queue_item(mm_pkg::OP_LOAD_B, 7, 0, -16'sd1);
    queue_item(mm_pkg::OP_COMPUTE, 7, 7, -16'sd1);
    queue_item(mm_pkg::OP_LOAD_A, 0, 0, 16'sh0000);
    queue_item(mm_pkg::OP_LOAD_B, 0, 0, 16'sh0001);
    queue_item(mm_pkg::OP_COMPUTE, 0, 0, 16'sh0000);
    queue_item(OP_UNUSED, 0, 0, 16'sh0000);
    queue_item(mm_pkg::OP_COMPUTE, 3, 5, 16'sh5a5a);
    drain_block(SETTLE_CYCLES);

    // random phases over several dimension settings and idling patterns
    for (int p = 0; p < N_PHASES; p++) begin
      write_dims(ph_rows[p], ph_inner[p], ph_cols[p]);
      set_idle(ph_mode[p]);
      items_made = 0;
      while (items_made < ph_count[p]) begin
        if ($urandom_range(0, 9) == 0)
          queue_noise();
        else
          queue_product_seq(dim_used(mm_pkg::DIM_W'(ph_rows[p])),
                            dim_used(mm_pkg::DIM_W'(ph_inner[p])),
                            dim_used(mm_pkg::DIM_W'(ph_cols[p])));
      end
      drain_block(SETTLE_CYCLES);
    end

    drain_block(2 * SETTLE_CYCLES);
    $display("covered %0d transactions (%0d loads, %0d computes) over %0d dimension settings",
             items_accepted, loads_seen, computes_seen, N_PHASES + 1);
    $display("checked %0d product elements, %0d errors", elems_checked, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
